[design/ilscan_pkg.sv]
// Shared types and constants for the inline link scanner.
package ilscan_pkg;

    localparam int MAX_LINE_LEN = 4096;
    localparam int POS_W        = $clog2(MAX_LINE_LEN + 1);

    localparam int CHAR_W  = 21;
    localparam int COUNT_W = 12;
    localparam int CHARS_W = 13;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CHARS_W-1:0] t_chars;
    typedef logic [POS_W-1:0]   t_pos;

    localparam t_char CH_BACKSLASH = t_char'(8'h5C);
    localparam t_char CH_LBRACKET  = t_char'(8'h5B);
    localparam t_char CH_RBRACKET  = t_char'(8'h5D);
    localparam t_char CH_LPAREN    = t_char'(8'h28);
    localparam t_char CH_RPAREN    = t_char'(8'h29);

    localparam t_count COUNT_MAX = '1;
    localparam t_chars CHARS_MAX = '1;
    localparam t_pos   POS_MAX   = t_pos'(MAX_LINE_LEN);

    typedef enum logic [5:0] {
        S_PLAIN  = 6'b000001,
        S_ESCAPE = 6'b000010,
        S_OPENED = 6'b000100,
        S_TEXT   = 6'b001000,
        S_CLOSED = 6'b010000,
        S_TARGET = 6'b100000
    } t_scan_state;

endpackage

[design/inline_link_scanner_top.sv]
// Inline link scanner: counts [text](target) links per line, sums target lengths (each with its '(').
//
// Input channel: i_in_valid / o_in_stall carry one character (i_char_code) or a
// line terminator (i_line_end = 1) per transfer. Output channel: o_out_valid /
// i_out_stall carry one result (o_link_count, o_link_chars) per line terminator;
// plain characters produce no result.
// Throughput: one input transfer per cycle, sustained while o_in_stall is low. Each transfer lands in an
// input register; while it is held there, one pass of the scan FSM and its counters
// updates the line state and, for a terminator, loads the result register.
// The output register frees the input side, so characters keep flowing while a
// result waits; only a second terminator stalls behind an unaccepted result,
// and o_in_stall stays high until that result transfers.
// Characters past the first MAX_LINE_LEN of a line are dropped.
// Reset (synchronous, i_rst_n low) empties both registers and returns the scan
// to plain text with all counts zero. While i_out_stall is high the pending
// result holds steady.
module inline_link_scanner_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ilscan_pkg::t_char      i_char_code,
    input  logic                   i_line_end,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ilscan_pkg::t_count     o_link_count,
    output ilscan_pkg::t_chars     o_link_chars
);
    import ilscan_pkg::*;

    logic        r_in_valid;
    t_char       r_in_char;
    logic        r_in_end;

    t_scan_state r_state, n_state;
    t_count      r_count, n_count;
    t_chars      r_chars, n_chars;
    t_chars      r_pending, n_pending;
    t_pos        r_pos, n_pos;

    logic        r_out_valid;
    t_count      r_out_count;
    t_chars      r_out_chars;

    logic        out_blocked;
    logic        proc_go;
    logic [CHARS_W:0] chars_sum;

    assign out_blocked = r_out_valid && i_out_stall;
    assign proc_go     = r_in_valid && !(r_in_end && out_blocked);
    assign o_in_stall  = r_in_valid && !proc_go;

    assign chars_sum = {1'b0, r_chars} + {1'b0, r_pending};

    // one character or line terminator through the scan FSM
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_chars   = r_chars;
        n_pending = r_pending;
        n_pos     = r_pos;
        if (r_in_end) begin
            n_state   = S_PLAIN;
            n_count   = '0;
            n_chars   = '0;
            n_pending = '0;
            n_pos     = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + t_pos'(1);
            unique case (r_state)
                S_ESCAPE: n_state = S_PLAIN;
                S_OPENED: n_state = (r_in_char == CH_RBRACKET) ? S_PLAIN : S_TEXT;
                S_TEXT: begin
                    if (r_in_char == CH_RBRACKET) n_state = S_CLOSED;
                end
                S_CLOSED: begin
                    if (r_in_char == CH_LPAREN) begin
                        n_pending = t_chars'(1);
                        n_state   = S_TARGET;
                    end else begin
                        n_state = S_PLAIN;
                    end
                end
                S_TARGET: begin
                    if (r_in_char == CH_RPAREN) begin
                        if (r_count != COUNT_MAX) n_count = r_count + t_count'(1);
                        n_chars   = chars_sum[CHARS_W] ? CHARS_MAX : chars_sum[CHARS_W-1:0];
                        n_pending = '0;
                        n_state   = S_PLAIN;
                    end else if (r_pending != CHARS_MAX) begin
                        n_pending = r_pending + t_chars'(1);
                    end
                end
                S_PLAIN: begin
                    if (r_in_char == CH_BACKSLASH)     n_state = S_ESCAPE;
                    else if (r_in_char == CH_LBRACKET) n_state = S_OPENED;
                    else                               n_state = S_PLAIN;
                end
                default: n_state = S_PLAIN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_char <= i_char_code;
            r_in_end  <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_PLAIN;
            r_count   <= '0;
            r_chars   <= '0;
            r_pending <= '0;
            r_pos     <= '0;
        end else if (proc_go) begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chars   <= n_chars;
            r_pending <= n_pending;
            r_pos     <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && r_in_end) begin
            r_out_count <= r_count;
            r_out_chars <= r_chars;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_link_count = r_out_count;
    assign o_link_chars = r_out_chars;

    // a new result only ever follows a processed terminator
    a_out_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_in_valid && r_in_end))
        else $error("result appeared without a line terminator");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && r_in_end) |=> (r_state == S_PLAIN && r_count == '0 &&
                                   r_chars == '0 && r_pos == '0))
        else $error("line state not cleared after terminator");

    a_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_TARGET) |-> (r_pending == '0))
        else $error("pending target length outside a target");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("line position past limit");

endmodule

[bench/inline_link_scanner_top_tb.sv]
// Self-checking testbench for inline_link_scanner_top: directed and random lines with links, line tallies checked.
`timescale 1ns / 100ps

module inline_link_scanner_top_tb;
    import ilscan_pkg::*;

    localparam t_char CODE_MAX   = t_char'(1114111);
    localparam int    PHASE_SIZE = 325;

    typedef struct packed {
        t_char code;
        logic  eol;
    } t_scan_item;

    typedef struct packed {
        t_count links;
        t_chars chars;
    } t_line_tally;

    bit     i_clk;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    t_char  i_char_code = '0;
    logic   i_line_end  = 1'b0;
    logic   i_out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_count o_link_count;
    t_chars o_link_chars;

    inline_link_scanner_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .i_line_end   (i_line_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_link_count (o_link_count),
        .o_link_chars (o_link_chars)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_scan_item  char_q[$];
    t_line_tally tally_q[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          phase_items    = 0;
    int          fail_count     = 0;
    logic        in_taken       = 1'b0;

    // Line scan predictor state
    t_scan_state scan_q      = S_PLAIN;
    t_count      links_acc   = '0;
    t_chars      target_acc  = '0;
    t_chars      target_run  = '0;
    t_pos        line_pos    = '0;

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic predict_transfer(input t_char c, input logic eol);
        logic [CHARS_W:0] sum;
        if (eol) begin
            tally_q.push_back('{links: links_acc, chars: target_acc});
            scan_q     = S_PLAIN;
            links_acc  = '0;
            target_acc = '0;
            target_run = '0;
            line_pos   = '0;
        end else if (line_pos < POS_MAX) begin
            line_pos++;
            case (scan_q)
                S_ESCAPE: scan_q = S_PLAIN;
                S_OPENED: scan_q = (c == CH_RBRACKET) ? S_PLAIN : S_TEXT;
                S_TEXT: begin
                    if (c == CH_RBRACKET)
                        scan_q = S_CLOSED;
                end
                S_CLOSED: begin
                    if (c == CH_LPAREN) begin
                        target_run = t_chars'(1);
                        scan_q     = S_TARGET;
                    end else begin
                        scan_q = S_PLAIN;
                    end
                end
                S_TARGET: begin
                    if (c == CH_RPAREN) begin
                        if (links_acc != COUNT_MAX)
                            links_acc++;
                        sum        = {1'b0, target_acc} + {1'b0, target_run};
                        target_acc = (sum > CHARS_MAX) ? CHARS_MAX : t_chars'(sum);
                        target_run = '0;
                        scan_q     = S_PLAIN;
                    end else if (target_run != CHARS_MAX) begin
                        target_run++;
                    end
                end
                default: begin
                    if (c == CH_BACKSLASH)
                        scan_q = S_ESCAPE;
                    else if (c == CH_LBRACKET)
                        scan_q = S_OPENED;
                    else
                        scan_q = S_PLAIN;
                end
            endcase
        end
    endtask

    // Monitor: sample input transfers, run the predictor, check results
    always @(posedge i_clk) begin
        t_line_tally want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                predict_transfer(i_char_code, i_line_end);
            if (o_out_valid && !i_out_stall) begin
                if (tally_q.size() == 0) begin
                    note_failure($sformatf("unexpected result count=%0d chars=%0d",
                                           o_link_count, o_link_chars));
                end else begin
                    want = tally_q.pop_front();
                    if (o_link_count !== want.links || o_link_chars !== want.chars)
                        note_failure($sformatf("count exp %0d got %0d, chars exp %0d got %0d",
                                               want.links, o_link_count,
                                               want.chars, o_link_chars));
                end
            end
        end
    end

    // Driver: holds a stalled transfer, otherwise maybe idles, otherwise sends the next item
    always @(negedge i_clk) begin
        t_scan_item item;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!(i_in_valid && !in_taken)) begin
                if (char_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item = char_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_char_code <= item.code;
                    i_line_end  <= item.eol;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic push_item(input t_char c, input logic eol);
        char_q.push_back('{code: c, eol: eol});
        phase_items++;
    endtask

    function automatic t_char pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            case ($urandom_range(0, 4))
                0: return CH_BACKSLASH;
                1: return CH_LBRACKET;
                2: return CH_RBRACKET;
                3: return CH_LPAREN;
                default: return CH_RPAREN;
            endcase
        end
        if (sel < 80)
            return t_char'($urandom_range(8'h20, 8'h7E));
        return t_char'($urandom_range(0, 1114111));
    endfunction

    task automatic push_link_text();
        t_char c;
        repeat ($urandom_range(1, 4)) begin
            c = pick_char();
            push_item((c == CH_RBRACKET) ? CH_BACKSLASH : c, 1'b0);
        end
    endtask

    task automatic push_target(input logic closed);
        t_char c;
        repeat ($urandom_range(0, 5)) begin
            c = pick_char();
            push_item((c == CH_RPAREN) ? CH_LBRACKET : c, 1'b0);
        end
        if (closed)
            push_item(CH_RPAREN, 1'b0);
    endtask

    task automatic add_random_line();
        int kind;
        repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                push_item(CH_LBRACKET, 1'b0);
                push_link_text();
                push_item(CH_RBRACKET, 1'b0);
                push_item(CH_LPAREN, 1'b0);
                push_target(1'b1);
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 4))
                    push_item(t_char'($urandom_range(8'h20, 8'h7E)), 1'b0);
            end else if (kind < 75) begin
                push_item(CH_BACKSLASH, 1'b0);
                push_item(pick_char(), 1'b0);
            end else if (kind < 85) begin
                // broken constructs: empty brackets, a random character after ']', unclosed target
                push_item(CH_LBRACKET, 1'b0);
                case ($urandom_range(0, 2))
                    0: push_item(CH_RBRACKET, 1'b0);
                    1: begin
                        push_link_text();
                        push_item(CH_RBRACKET, 1'b0);
                        push_item(pick_char(), 1'b0);
                    end
                    default: begin
                        push_link_text();
                        push_item(CH_RBRACKET, 1'b0);
                        push_item(CH_LPAREN, 1'b0);
                        push_target(1'b0);
                    end
                endcase
            end else begin
                push_item(pick_char(), 1'b0);
            end
        end
        push_item(t_char'($urandom_range(0, 1114111)), 1'b1);
    endtask

    // Line longer than MAX_LINE_LEN, full of links, the tail must be dropped
    task automatic add_long_line();
        repeat ($urandom_range(0, 7))
            push_item(t_char'($urandom_range(8'h61, 8'h7A)), 1'b0);
        repeat (MAX_LINE_LEN / 8 + 1) begin
            push_item(CH_LBRACKET, 1'b0);
            push_item(t_char'($urandom_range(8'h61, 8'h7A)), 1'b0);
            push_item(CH_RBRACKET, 1'b0);
            push_item(CH_LPAREN, 1'b0);
            repeat (3)
                push_item(t_char'($urandom_range(8'h61, 8'h7A)), 1'b0);
            push_item(CH_RPAREN, 1'b0);
        end
        push_item(CODE_MAX, 1'b1);
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        // empty line
        push_item(CODE_MAX, 1'b1);
        // escaped '[', empty brackets, missing '(', then a link with extreme codes
        push_item(CH_BACKSLASH, 1'b0);
        push_item(CH_LBRACKET, 1'b0);
        push_item(CH_LBRACKET, 1'b0);
        push_item(CH_RBRACKET, 1'b0);
        push_item(CH_LBRACKET, 1'b0);
        push_item('0, 1'b0);
        push_item(CH_RBRACKET, 1'b0);
        push_item(t_char'(8'h78), 1'b0);
        push_item(CH_LBRACKET, 1'b0);
        push_item(CH_BACKSLASH, 1'b0);
        push_item(CH_RBRACKET, 1'b0);
        push_item(CH_LPAREN, 1'b0);
        push_item(CODE_MAX, 1'b0);
        push_item(CH_RPAREN, 1'b0);
        push_item('0, 1'b1);
        // unclosed target dropped at line end
        push_item(CH_LBRACKET, 1'b0);
        push_item(t_char'(8'h61), 1'b0);
        push_item(CH_RBRACKET, 1'b0);
        push_item(CH_LPAREN, 1'b0);
        push_item(t_char'(8'h62), 1'b0);
        push_item(t_char'(8'h63), 1'b0);
        push_item(CH_RPAREN, 1'b1);
        // line ends on an open escape
        push_item(CH_BACKSLASH, 1'b0);
        push_item(CH_LBRACKET, 1'b1);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_SIZE)
                add_random_line();
            if (phase == 3)
                add_long_line();
            wait_drained();
        end

        while (tally_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("inline_link_scanner_top verification clean");
        else
            $display("inline_link_scanner_top verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("inline_link_scanner_top verification failed");
        $finish;
    end

endmodule

[inline_link_scanner_top.f]
design/ilscan_pkg.sv
design/inline_link_scanner_top.sv
bench/inline_link_scanner_top_tb.sv
